/* hdl/lj_coulomb_site_potential_defines.svh */
// Assertion macros shared by the site potential RTL
`ifndef LJ_COULOMB_SITE_POTENTIAL_DEFINES_SVH
`define LJ_COULOMB_SITE_POTENTIAL_DEFINES_SVH
`ifndef SYNTHESIS
`define LJ_ASSERT_COMB(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define LJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LJ_ASSERT_COMB(label, clk, rst_n, cond, msg)
`define LJ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/lj_pkg.sv */
// Types and constants for the site potential pipeline
`timescale 1ns / 1ps
package lj_pkg;

    localparam int GRID_POINTS_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_KT    = 2'd1;

    localparam logic [19:0] GRID_STEP_RST = 20'd3277;
    localparam logic [31:0] INV_KT_RST    = 32'd28147497;

    localparam logic [8:0]  COUL_FACTOR = 9'd332;
    localparam logic [47:0] POS_MAX     = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAX     = 48'h8000_0000_0000;

    // unit sizes
    localparam int SQRT_W  = 48;
    localparam int DIV_NUM = 63;
    localparam int DIV_DEN = 32;

    typedef struct packed {
        logic [11:0]        grid_index;
        logic [23:0]        solvent_sigma;
        logic [23:0]        solute_sigma;
        logic [23:0]        solvent_epsilon;
        logic [23:0]        solute_epsilon;
        logic signed [19:0] solvent_charge;
        logic signed [19:0] solute_charge;
    } in_t;

    typedef struct packed {
        logic signed [47:0] reduced_potential;
        logic               saturated;
    } out_t;

endpackage

/* hdl/lj_coulomb_site_potential.sv */
// Top level: reduced Lennard-Jones plus Coulomb site potential pipeline
//
//  channel   | handshake                 | beat
//  ----------+---------------------------+------------------------------
//  item      | item_valid / item_stall   | lj_pkg::in_t (pair, grid index)
//  result    | result_valid / result_stall | lj_pkg::out_t
//  cfg       | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One beat per cycle in, one per cycle out while no stalled result holds the
// pipeline; the 24-stage square root and the 63-stage dividers lie in series.
// The whole pipeline advances together; a stalled result freezes every stage
// and raises item_stall. Reset clears valid bits and loads register defaults.
`timescale 1ns / 1ps
module lj_coulomb_site_potential #(
    parameter int GRID_POINTS = lj_pkg::GRID_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  lj_pkg::in_t                   item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output lj_pkg::out_t                  result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lj_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lj_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lj_pkg::*;
`include "lj_coulomb_site_potential_defines.svh"

    typedef struct packed {
        logic        idx_bad;
        logic [31:0] r;
        logic [24:0] s2;
        logic [38:0] qm;
        logic        cneg;
    } pre_t;

    typedef struct packed {
        logic        bad;
        logic [25:0] e4;
    } xside_t;

    typedef struct packed {
        logic        bad;
        logic [25:0] e4;
        logic        cneg;
        logic [63:0] coul;
    } ljs_t;

    typedef struct packed {
        ljs_t        base;
        logic [63:0] x2;
    } ljs2_t;

    typedef struct packed {
        ljs_t base;
        logic ljneg;
    } ljsn_t;

    typedef struct packed {
        logic bad;
        logic ljovf;
        logic neg;
    } fin_t;

    logic        en;
    logic [19:0] grid_step_reg;
    logic [31:0] inv_kt_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_step_reg <= GRID_STEP_RST;
            inv_kt_reg    <= INV_KT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRID_STEP: grid_step_reg <= cfg_data[19:0];
                REG_INV_KT:    inv_kt_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    logic  result_valid_reg;
    out_t  result_reg;

    assign en         = !(result_valid_reg && result_stall);
    assign item_stall = !en;

    // stage 0: products of the inputs
    logic        s0_v_reg;
    pre_t        s0_reg, s0_next;
    logic [47:0] s0_pe_reg;
    logic [19:0] qa_mag, qb_mag;

    always_comb
    begin
        qa_mag = item.solvent_charge[19] ? 20'(-item.solvent_charge) : item.solvent_charge;
        qb_mag = item.solute_charge[19]  ? 20'(-item.solute_charge)  : item.solute_charge;
        s0_next.idx_bad = (item.grid_index == 12'd0)
                       || (32'(item.grid_index) >= 32'(GRID_POINTS));
        s0_next.r    = 32'({20'd0, item.grid_index} * {12'd0, grid_step_reg});
        s0_next.s2   = {1'b0, item.solvent_sigma} + {1'b0, item.solute_sigma};
        s0_next.qm   = 39'({20'd0, qa_mag} * {20'd0, qb_mag});
        s0_next.cneg = item.solvent_charge[19] ^ item.solute_charge[19];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg    <= s0_next;
            s0_pe_reg <= 48'({24'd0, item.solvent_epsilon} * {24'd0, item.solute_epsilon});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (en)
            s0_v_reg <= item_valid;
    end

    // geometric mean of the well depths
    logic                sq_v;
    logic [SQRT_W/2-1:0] sq_root;
    pre_t                sq_side;

    lj_sqrt #(
        .VAL_W  (SQRT_W),
        .SIDE_W ($bits(pre_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .op_valid  (s0_v_reg),
        .op        (s0_pe_reg),
        .op_side   (s0_reg),
        .res_valid (sq_v),
        .res       (sq_root),
        .res_side  (sq_side)
    );

    // stage 1: dividend setup
    logic               s1_v_reg;
    logic [DIV_NUM-1:0] s1_numx_reg, s1_numc_reg;
    logic [31:0]        s1_r_reg;
    xside_t             s1_xs_reg;
    logic               s1_cneg_reg;
    logic [47:0]        coul_prod;

    assign coul_prod = 48'({9'd0, sq_side.qm} * {39'd0, COUL_FACTOR});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_numx_reg   <= DIV_NUM'({sq_side.s2, 31'd0});
            s1_numc_reg   <= {coul_prod[46:0], 16'd0};
            s1_r_reg      <= sq_side.r;
            s1_xs_reg.bad <= sq_side.idx_bad || (sq_side.r == 32'd0);
            s1_xs_reg.e4  <= {sq_root, 2'b00};
            s1_cneg_reg   <= sq_side.cneg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= sq_v;
    end

    // sigma/r and Coulomb magnitude, side by side
    logic               xdiv_v, cdiv_v;
    logic [DIV_NUM-1:0] xq, cq;
    xside_t             xdiv_side;
    logic               cdiv_cneg;

    lj_div #(
        .NUM_W  (DIV_NUM),
        .DEN_W  (DIV_DEN),
        .SIDE_W ($bits(xside_t))
    ) u_xdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .op_valid (s1_v_reg),
        .num      (s1_numx_reg),
        .den      (s1_r_reg),
        .op_side  (s1_xs_reg),
        .q_valid  (xdiv_v),
        .quo      (xq),
        .q_side   (xdiv_side)
    );

    lj_div #(
        .NUM_W  (DIV_NUM),
        .DEN_W  (DIV_DEN),
        .SIDE_W (1)
    ) u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .op_valid (s1_v_reg),
        .num      (s1_numc_reg),
        .den      (s1_r_reg),
        .op_side  (s1_cneg_reg),
        .q_valid  (cdiv_v),
        .quo      (cq),
        .q_side   (cdiv_cneg)
    );

    ljs_t  m1_in_side;
    logic [63:0] xv;

    assign xv              = {1'b0, xq};
    assign m1_in_side.bad  = xdiv_side.bad;
    assign m1_in_side.e4   = xdiv_side.e4;
    assign m1_in_side.cneg = cdiv_cneg;
    assign m1_in_side.coul = {1'b0, cq};

    // x^2
    logic        m1_v, m1_ovf;
    logic [63:0] m1_p;
    ljs_t        m1_side;

    lj_mulshr #(.K(32), .SIDE_W($bits(ljs_t))) u_m1 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (xdiv_v), .a (xv), .b (xv), .op_ovf (1'b0), .op_side (m1_in_side),
        .p_valid (m1_v), .p (m1_p), .p_ovf (m1_ovf), .p_side (m1_side)
    );

    // x^4
    logic        m2_v, m2_ovf;
    logic [63:0] m2_p;
    ljs2_t       m2_in_side, m2_side;

    assign m2_in_side.base = m1_side;
    assign m2_in_side.x2   = m1_p;

    lj_mulshr #(.K(32), .SIDE_W($bits(ljs2_t))) u_m2 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (m1_v), .a (m1_p), .b (m1_p), .op_ovf (m1_ovf), .op_side (m2_in_side),
        .p_valid (m2_v), .p (m2_p), .p_ovf (m2_ovf), .p_side (m2_side)
    );

    // x^6
    logic        m3_v, m3_ovf;
    logic [63:0] m3_p;
    ljs_t        m3_side;

    lj_mulshr #(.K(32), .SIDE_W($bits(ljs_t))) u_m3 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (m2_v), .a (m2_p), .b (m2_side.x2), .op_ovf (m2_ovf),
        .op_side (m2_side.base),
        .p_valid (m3_v), .p (m3_p), .p_ovf (m3_ovf), .p_side (m3_side)
    );

    // |x6 - 1| and its sign
    logic        d_v_reg, d_ovf_reg;
    logic [63:0] d_x6_reg, d_d_reg;
    ljsn_t       d_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_x6_reg        <= m3_p;
            d_ovf_reg       <= m3_ovf;
            d_side_reg.base <= m3_side;
            if (m3_p >= 64'h1_0000_0000)
            begin
                d_d_reg          <= m3_p - 64'h1_0000_0000;
                d_side_reg.ljneg <= 1'b0;
            end
            else
            begin
                d_d_reg          <= 64'h1_0000_0000 - m3_p;
                d_side_reg.ljneg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (en)
            d_v_reg <= m3_v;
    end

    logic        m4_v, m4_ovf;
    logic [63:0] m4_p;
    ljsn_t       m4_side;

    lj_mulshr #(.K(32), .SIDE_W($bits(ljsn_t))) u_m4 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (d_v_reg), .a (d_x6_reg), .b (d_d_reg), .op_ovf (d_ovf_reg),
        .op_side (d_side_reg),
        .p_valid (m4_v), .p (m4_p), .p_ovf (m4_ovf), .p_side (m4_side)
    );

    // scale by epsilon
    logic        m5_v, m5_ovf;
    logic [63:0] m5_p;
    ljsn_t       m5_side;

    lj_mulshr #(.K(16), .SIDE_W($bits(ljsn_t))) u_m5 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (m4_v), .a (m4_p), .b ({38'd0, m4_side.base.e4}), .op_ovf (m4_ovf),
        .op_side (m4_side),
        .p_valid (m5_v), .p (m5_p), .p_ovf (m5_ovf), .p_side (m5_side)
    );

    // signed sum of both terms
    logic        sm_v_reg, sm_clip_reg;
    logic [63:0] sm_sum_reg;
    fin_t        sm_side_reg;
    logic        lj_on, lj_neg_eff;
    logic [63:0] lj_eff, coul_m;
    logic [64:0] add_full;

    always_comb
    begin
        lj_on      = (m5_side.base.e4 != 26'd0);
        lj_eff     = lj_on ? m5_p : 64'd0;
        lj_neg_eff = lj_on && m5_side.ljneg;
        coul_m     = m5_side.base.coul;
        add_full   = {1'b0, lj_eff} + {1'b0, coul_m};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sm_side_reg.bad   <= m5_side.base.bad;
            sm_side_reg.ljovf <= lj_on && m5_ovf;
            if (lj_neg_eff == m5_side.base.cneg)
            begin
                sm_side_reg.neg <= lj_neg_eff;
                sm_sum_reg      <= add_full[64] ? '1 : add_full[63:0];
                sm_clip_reg     <= add_full[64];
            end
            else if (lj_eff >= coul_m)
            begin
                sm_side_reg.neg <= lj_neg_eff;
                sm_sum_reg      <= lj_eff - coul_m;
                sm_clip_reg     <= 1'b0;
            end
            else
            begin
                sm_side_reg.neg <= m5_side.base.cneg;
                sm_sum_reg      <= coul_m - lj_eff;
                sm_clip_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_v_reg <= 1'b0;
        else if (en)
            sm_v_reg <= m5_v;
    end

    // times inverse kT, Q32.32 * Q8.24 >> 40 gives Q.16
    logic        fin_v, fin_ovf;
    logic [63:0] fin_p;
    fin_t        fin_side;

    lj_mulshr #(.K(40), .SIDE_W($bits(fin_t))) u_m6 (
        .clk (clk), .rst_n (rst_n), .en (en),
        .op_valid (sm_v_reg), .a (sm_sum_reg), .b ({32'd0, inv_kt_reg}),
        .op_ovf (sm_clip_reg), .op_side (sm_side_reg),
        .p_valid (fin_v), .p (fin_p), .p_ovf (fin_ovf), .p_side (fin_side)
    );

    // clip, sign and special cases
    out_t result_next;

    always_comb
    begin
        result_next.reduced_potential = '0;
        result_next.saturated         = 1'b1;
        if (fin_side.bad)
        begin
            result_next.reduced_potential = '0;
            result_next.saturated         = 1'b1;
        end
        else if (fin_side.ljovf)
        begin
            result_next.reduced_potential = POS_MAX;
            result_next.saturated         = 1'b1;
        end
        else if (fin_side.neg)
        begin
            if (fin_p > {16'd0, NEG_MAX})
            begin
                result_next.reduced_potential = NEG_MAX;
                result_next.saturated         = 1'b1;
            end
            else
            begin
                result_next.reduced_potential = ~fin_p[47:0] + 48'd1;
                result_next.saturated         = fin_ovf;
            end
        end
        else if (fin_p > {16'd0, POS_MAX})
        begin
            result_next.reduced_potential = POS_MAX;
            result_next.saturated         = 1'b1;
        end
        else
        begin
            result_next.reduced_potential = fin_p[47:0];
            result_next.saturated         = fin_ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (en)
            result_valid_reg <= fin_v;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `LJ_ASSERT_COMB(a_div_lockstep, clk, rst_n, xdiv_v == cdiv_v, "divider lanes out of step")
    `LJ_ASSERT_NEXT(a_bad_zero, clk, rst_n, en && fin_v && fin_side.bad, result_reg.saturated && result_reg.reduced_potential == 48'sd0, "off-grid item not zeroed")
    `LJ_ASSERT_NEXT(a_lj_ovf, clk, rst_n, en && fin_v && !fin_side.bad && fin_side.ljovf, result_reg.saturated && result_reg.reduced_potential == POS_MAX, "LJ overflow not clipped high")

endmodule

/* hdl/lj_sqrt.sv */
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
module lj_sqrt #(
    parameter int VAL_W  = 48,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 op_valid,
    input  logic [VAL_W-1:0]     op,
    input  logic [SIDE_W-1:0]    op_side,
    output logic                 res_valid,
    output logic [VAL_W/2-1:0]   res,
    output logic [SIDE_W-1:0]    res_side
);
    localparam int STEPS = VAL_W / 2;

    logic              v_reg    [STEPS];
    logic [VAL_W-1:0]  rem_reg  [STEPS];
    logic [VAL_W:0]    root_reg [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic [VAL_W:0] BIT = (VAL_W+1)'(1) << (2 * (STEPS - 1 - i));
        logic              st_v;
        logic [VAL_W-1:0]  st_rem;
        logic [VAL_W:0]    st_root;
        logic [SIDE_W-1:0] st_side;
        logic [VAL_W:0]    trial;
        logic [VAL_W-1:0]  rem_next;
        logic [VAL_W:0]    root_next;

        if (i == 0) begin : g_first
            assign st_v    = op_valid;
            assign st_rem  = op;
            assign st_root = '0;
            assign st_side = op_side;
        end
        else begin : g_rest
            assign st_v    = v_reg[i-1];
            assign st_rem  = rem_reg[i-1];
            assign st_root = root_reg[i-1];
            assign st_side = side_reg[i-1];
        end

        always_comb
        begin
            trial = st_root + BIT;
            if ({1'b0, st_rem} >= trial)
            begin
                rem_next  = st_rem - trial[VAL_W-1:0];
                root_next = (st_root >> 1) + BIT;
            end
            else
            begin
                rem_next  = st_rem;
                root_next = st_root >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= st_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= st_side;
            end
        end
    end

    assign res_valid = v_reg[STEPS-1];
    assign res       = root_reg[STEPS-1][STEPS-1:0];
    assign res_side  = side_reg[STEPS-1];

endmodule

/* hdl/lj_div.sv */
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module lj_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              op_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] op_side,
    output logic              q_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] q_side
);
    logic              v_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_step
        logic              st_v;
        logic [DEN_W-1:0]  st_rem;
        logic [NUM_W-1:0]  st_num;
        logic [DEN_W-1:0]  st_den;
        logic [NUM_W-1:0]  st_quo;
        logic [SIDE_W-1:0] st_side;
        logic [DEN_W:0]    shifted;
        logic [DEN_W-1:0]  rem_next;
        logic              qbit;

        if (i == 0) begin : g_first
            assign st_v    = op_valid;
            assign st_rem  = '0;
            assign st_num  = num;
            assign st_den  = den;
            assign st_quo  = '0;
            assign st_side = op_side;
        end
        else begin : g_rest
            assign st_v    = v_reg[i-1];
            assign st_rem  = rem_reg[i-1];
            assign st_num  = num_reg[i-1];
            assign st_den  = den_reg[i-1];
            assign st_quo  = quo_reg[i-1];
            assign st_side = side_reg[i-1];
        end

        always_comb
        begin
            shifted = {st_rem, st_num[NUM_W-1-i]};
            qbit    = (shifted >= {1'b0, st_den});
            if (qbit)
                rem_next = shifted[DEN_W-1:0] - st_den;
            else
                rem_next = shifted[DEN_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= st_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                num_reg[i]  <= st_num;
                den_reg[i]  <= st_den;
                quo_reg[i]  <= {st_quo[NUM_W-2:0], qbit};
                side_reg[i] <= st_side;
            end
        end
    end

    assign q_valid = v_reg[NUM_W-1];
    assign quo     = quo_reg[NUM_W-1];
    assign q_side  = side_reg[NUM_W-1];

endmodule

/* hdl/lj_mulshr.sv */
// Two-stage 64x64 multiply, shift right by K, saturate at all ones
`timescale 1ns / 1ps
module lj_mulshr #(
    parameter int K      = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              op_valid,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    input  logic              op_ovf,
    input  logic [SIDE_W-1:0] op_side,
    output logic              p_valid,
    output logic [63:0]       p,
    output logic              p_ovf,
    output logic [SIDE_W-1:0] p_side
);
    logic              v1_reg, v2_reg;
    logic [63:0]       pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic              ovf1_reg, ovf2_reg;
    logic [SIDE_W-1:0] side1_reg, side2_reg;
    logic [63:0]       p_reg;

    logic [33:0]       mid;
    logic [63:0]       hi;
    logic [127:0]      full;
    logic              big;
    logic [63:0]       p_next;

    // partial products, 32x32 each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg  <= a[31:0]  * b[31:0];
            pp01_reg  <= a[31:0]  * b[63:32];
            pp10_reg  <= a[63:32] * b[31:0];
            pp11_reg  <= a[63:32] * b[63:32];
            ovf1_reg  <= op_ovf;
            side1_reg <= op_side;
        end
    end

    always_comb
    begin
        mid  = {2'b00, pp00_reg[63:32]} + {2'b00, pp01_reg[31:0]} + {2'b00, pp10_reg[31:0]};
        hi   = pp11_reg + {32'd0, pp01_reg[63:32]} + {32'd0, pp10_reg[63:32]}
             + {62'd0, mid[33:32]};
        full = {hi, mid[31:0], pp00_reg[31:0]};
        big  = ((hi >> K) != 64'd0);
        p_next = big ? '1 : full[K+63:K];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= p_next;
            ovf2_reg  <= ovf1_reg | big;
            side2_reg <= side1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= op_valid;
            v2_reg <= v1_reg;
        end
    end

    assign p_valid = v2_reg;
    assign p       = p_reg;
    assign p_ovf   = ovf2_reg;
    assign p_side  = side2_reg;

endmodule

/* verif/testbench.sv */
// Testbench for the reduced Lennard-Jones plus Coulomb site potential pipeline
`timescale 1ns / 1ps
module testbench;
    import lj_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    in_t item;
    logic result_valid;
    logic result_stall;
    out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lj_coulomb_site_potential DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // local copy of the block registers
    logic [19:0] step_reg;
    logic [31:0] beta_reg;

    in_t pending_pairs[$];
    out_t expected_potentials[$];
    bit idle_on;
    bit item_taken;
    int item_gap;
    int result_gap;
    int mismatches;
    int pairs_sent;
    int potentials_seen;
    int saturated_seen;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // (a*b) >> k; bit 64 flags that the result does not fit in 64 bits
    function automatic logic [64:0] mul_shift(logic [63:0] a, logic [63:0] b, int k);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + k)) != 0)
            return {1'b1, 64'hFFFF_FFFF_FFFF_FFFF};
        return {1'b0, 64'(p >> k)};
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic out_t site_potential(in_t it);
        logic [63:0] r, e4, x, x2, x6, d, c, lj, coul, qm, sum, scaled, qa, qb;
        logic [64:0] t, s;
        bit ovf, clip, lj_neg, coul_neg, neg;
        out_t o;
        o = '0;
        ovf = 0;
        clip = 0;
        lj_neg = 0;
        lj = 0;
        if (it.grid_index == 0 || it.grid_index >= GRID_POINTS_DEF)
        begin
            o.saturated = 1'b1;
            return o;
        end
        r = 64'(it.grid_index) * 64'(step_reg);
        if (r == 0)
        begin
            o.saturated = 1'b1;
            return o;
        end
        e4 = 4 * int_sqrt(64'(it.solvent_epsilon) * 64'(it.solute_epsilon));
        if (e4 != 0)
        begin
            x = ((64'(it.solvent_sigma) + 64'(it.solute_sigma)) << 31) / r;
            t = mul_shift(x, x, 32);
            ovf |= t[64];
            x2 = t[63:0];
            t = mul_shift(x2, x2, 32);
            ovf |= t[64];
            t = mul_shift(t[63:0], x2, 32);
            ovf |= t[64];
            x6 = t[63:0];
            if (x6 >= ONE_Q32)
                d = x6 - ONE_Q32;
            else
            begin
                d = ONE_Q32 - x6;
                lj_neg = 1;
            end
            t = mul_shift(x6, d, 32);
            ovf |= t[64];
            c = t[63:0];
            t = mul_shift(c, e4, 16);
            ovf |= t[64];
            lj = t[63:0];
            if (ovf)
            begin
                o.reduced_potential = POS_MAX;
                o.saturated = 1'b1;
                return o;
            end
        end
        qa = it.solvent_charge < 0 ? 64'(-64'(it.solvent_charge)) : 64'(it.solvent_charge);
        qb = it.solute_charge < 0 ? 64'(-64'(it.solute_charge)) : 64'(it.solute_charge);
        coul_neg = (it.solvent_charge < 0) != (it.solute_charge < 0);
        qm = qa * qb;
        coul = ((64'(COUL_FACTOR) * qm) << 16) / r;
        if (lj_neg == coul_neg)
        begin
            neg = lj_neg;
            s = {1'b0, lj} + {1'b0, coul};
            sum = s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
            clip = s[64];
        end
        else if (lj >= coul)
        begin
            neg = lj_neg;
            sum = lj - coul;
        end
        else
        begin
            neg = coul_neg;
            sum = coul - lj;
        end
        t = mul_shift(sum, 64'(beta_reg), 40);
        clip |= t[64];
        scaled = t[63:0];
        if (neg)
        begin
            if (scaled > 64'(NEG_MAX))
            begin
                scaled = 64'(NEG_MAX);
                clip = 1;
            end
            scaled = -scaled;
        end
        else if (scaled > 64'(POS_MAX))
        begin
            scaled = 64'(POS_MAX);
            clip = 1;
        end
        o.reduced_potential = scaled[47:0];
        o.saturated = clip;
        return o;
    endfunction

    task automatic report(string what, out_t got, out_t want);
        $display("mismatch %0s: got %0d/%0b want %0d/%0b", what,
                 got.reduced_potential, got.saturated,
                 want.reduced_potential, want.saturated);
        mismatches++;
    endtask

    // item side
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (item_gap > 0)
            begin
                item_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_pairs.size() != 0 && idle_on && $urandom_range(0, 11) == 0)
            begin
                item_gap = $urandom_range(0, 15);
                item_valid <= 1'b0;
            end
            else if (pending_pairs.size() != 0)
            begin
                item <= pending_pairs.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (result_gap > 0)
        begin
            result_gap--;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 11) == 0)
        begin
            result_gap = $urandom_range(0, 15);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        item_taken <= item_valid && !item_stall;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                expected_potentials.push_back(site_potential(item));
                pairs_sent++;
            end
            if (result_valid && !result_stall)
            begin
                potentials_seen++;
                if (result.saturated)
                    saturated_seen++;
                if (expected_potentials.size() == 0)
                    report("unexpected beat", result, '0);
                else
                begin
                    out_t want;
                    want = expected_potentials.pop_front();
                    if (result.reduced_potential !== want.reduced_potential)
                        report("potential", result, want);
                    if (result.saturated !== want.saturated)
                        report("saturated flag", result, want);
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout, %0d potentials still expected",
                         expected_potentials.size());
                $display("[lj_coulomb_site_potential] ERROR");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_GRID_STEP)
            step_reg = val[19:0];
        else if (idx == REG_INV_KT)
            beta_reg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || item_valid || expected_potentials.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic in_t pair_item(int idx, int sa, int sb, int ea, int eb, int qa, int qb);
        in_t it;
        it.grid_index = idx[11:0];
        it.solvent_sigma = sa[23:0];
        it.solute_sigma = sb[23:0];
        it.solvent_epsilon = ea[23:0];
        it.solute_epsilon = eb[23:0];
        it.solvent_charge = qa[19:0];
        it.solute_charge = qb[19:0];
        return it;
    endfunction

    function automatic in_t random_pair();
        in_t it;
        int kind;
        logic [191:0] raw;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            it = raw[$bits(in_t)-1:0];
        end
        else
            // physically sized pair: sigma 0..8 A, eps 0..2, charges +-2
            it = pair_item($urandom_range(1, 4095), $urandom_range(0, 1 << 19),
                           $urandom_range(0, 1 << 19), $urandom_range(0, 1 << 17),
                           $urandom_range(0, 1 << 17),
                           $signed($urandom_range(0, 1 << 18)) - (1 << 17),
                           $signed($urandom_range(0, 1 << 18)) - (1 << 17));
        if (kind == 9)
            it.grid_index = $urandom_range(0, 1) ? 12'd0 : 12'hFFF;
        return it;
    endfunction

    initial
    begin
        logic [19:0] steps[7];
        logic [31:0] betas[7];
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_on = 1'b1;
        item_gap = 0;
        result_gap = 0;
        quiet_cycles = 0;
        step_reg = GRID_STEP_RST;
        beta_reg = INV_KT_RST;
        steps = '{GRID_STEP_RST, 20'd1, 20'hFFFFF, 20'd0, 20'd6554, 20'd655, 20'd3277};
        betas = '{INV_KT_RST, 32'd1, 32'hFFFF_FFFF, INV_KT_RST, 32'd16777216,
                  32'd3000000000, 32'd28147497};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners under reset register values
        pending_pairs.push_back(pair_item(1, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(pair_item(0, 200000, 200000, 10000, 10000, 65536, 65536));
        pending_pairs.push_back(pair_item(4095, 200000, 200000, 10000, 10000, 65536, -65536));
        pending_pairs.push_back(pair_item(1, 200000, 200000, 10000, 10000, 0, 0));
        pending_pairs.push_back(pair_item(1, 0, 0, 0, 0, 524287, 524287));
        pending_pairs.push_back(pair_item(1, 0, 0, 0, 0, -524288, -524288));
        pending_pairs.push_back(pair_item(1, 0, 0, 0, 0, -524288, 524287));
        pending_pairs.push_back(pair_item(4095, 0, 0, 0, 0, -1, 1));
        pending_pairs.push_back(pair_item(1, 16777215, 16777215, 16777215, 16777215,
                                          524287, -524288));
        pending_pairs.push_back(pair_item(4095, 16777215, 16777215, 1, 1, 0, 0));
        pending_pairs.push_back(pair_item(4095, 1, 0, 16777215, 16777215, 0, 0));
        pending_pairs.push_back(pair_item(20, 206000, 206000, 10000, 10000, 27000, -54000));
        pending_pairs.push_back(pair_item(23, 206000, 206000, 10000, 10000, 27000, 27000));
        pending_pairs.push_back(pair_item(40, 206000, 206000, 10000, 10000, -27000, 27000));
        pending_pairs.push_back(pair_item(4095, 16777215, 16777215, 0, 16777215, 1, 1));
        pending_pairs.push_back(pair_item(2048, 300000, 100000, 65536, 0, 65536, 65536));
        drain();
        // stray index must leave the registers alone
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        pending_pairs.push_back(pair_item(30, 200000, 200000, 10000, 10000, 65536, -65536));
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            idle_on = (ph < 6);
            if (ph != 0)
            begin
                write_reg(REG_GRID_STEP, 32'(steps[ph]));
                write_reg(REG_INV_KT, betas[ph]);
            end
            for (int n = 0; n < 185; n++)
                pending_pairs.push_back(random_pair());
            drain();
        end

        $display("%0d pairs sent, %0d potentials checked (%0d saturated) over seven",
                 pairs_sent, potentials_seen, saturated_seen);
        $display("register settings, zero step and both extremes included");
        if (mismatches == 0 && expected_potentials.size() == 0)
            $display("[lj_coulomb_site_potential] OK");
        else
            $display("[lj_coulomb_site_potential] ERROR");
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/lj_pkg.sv
hdl/lj_sqrt.sv
hdl/lj_div.sv
hdl/lj_mulshr.sv
hdl/lj_coulomb_site_potential.sv
verif/testbench.sv
